/* rtl/core/tss_pkg.sv */
// Package for the thread slot scheduler: state codes, opcodes, status codes,
// scheduling modes, sequencer states, channel words and default parameters.
// No dependencies.
package tss_pkg;

  localparam int unsigned SLOTS_DEF    = 8;
  localparam int unsigned PRIO_MIN_DEF = 0;
  localparam int unsigned PRIO_MAX_DEF = 15;
  localparam int unsigned CFG_AW       = 1;
  localparam int unsigned CFG_DW       = 8;
  localparam logic [7:0]  STARVE_RESET = 8'd10;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } slot_state_e;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_EXIT     = 3'd2,
    OP_BLOCK    = 3'd3,
    OP_UNBLOCK  = 3'd4
  } op_e;

  localparam logic [2:0] STS_SWITCHED = 3'd0;
  localparam logic [2:0] STS_NONE     = 3'd1;
  localparam logic [2:0] STS_CREATED  = 3'd2;
  localparam logic [2:0] STS_FULL     = 3'd3;
  localparam logic [2:0] STS_DONE     = 3'd4;

  localparam logic [1:0] MODE_RR    = 2'd0;
  localparam logic [1:0] MODE_PRIO  = 2'd1;
  localparam logic [1:0] MODE_LOT   = 2'd2;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_STARVE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CREATE, S_AGE, S_RR, S_PSTARVE, S_PLVL, S_LSUM, S_LDIV,
    S_LWALK, S_COMMIT, S_OUT
  } seq_e;

  // Input word: one operation request.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  req_prio;
    logic [7:0]  ticket_count;
    logic [15:0] random_value;
    logic [2:0]  wake_slot;
  } op_word_t;

  // Output word: one answer per operation.
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot;
    logic [2:0] prev_slot;
  } status_word_t;

endpackage

/* rtl/core/tss_if.sv */
// Valid/ready channel carrying one word of payload type T.
// Depends on nothing; used with types from tss_pkg.
interface tss_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/thread_slot_scheduler.sv */
// Thread slot scheduler top level: slot table, sequencer and result register.
// Depends on tss_pkg, tss_if and tss_div.
//
// The block keeps a table of SLOTS thread slots and answers each input word
// with exactly one output word. A sequencer walks the table one slot per
// cycle, so the cost of an item is set by that walk. Unblock and undefined
// ops go straight to the output state; create scans for the first unused
// slot. Schedule, exit and block first age every slot and then select:
// round robin scans once round from the slot after its pointer; priority
// mode runs the starvation search and then a rotating scan per priority
// level from PRIO_MIN upward; lottery sums the tickets, takes the remainder
// in the bit-serial divider, walks the tickets and commits. An undefined
// mode answers after the aging pass. The input is not ready while an item is
// in work or while the finished word waits in the output register, so the
// next input word is accepted only after the output word has been taken.
// The configuration port should be written only while the block is idle:
// index 0 is sched_mode, index 1 starve_limit.
module thread_slot_scheduler import tss_pkg::*; #(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned PRIO_MIN = PRIO_MIN_DEF,
  parameter int unsigned PRIO_MAX = PRIO_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  tss_if.sink               in_if,
  tss_if.source             out_if
);
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = SW + 1;

  // Slot table. Priorities carry one extra code below PRIO_MIN as the
  // starvation boost mark, stored as a 6-bit signed value.
  slot_state_e        st_q  [SLOTS];
  logic signed [5:0]  pri_q [SLOTS];
  logic [3:0]         base_q[SLOTS];
  logic [7:0]         tik_q [SLOTS];
  logic [7:0]         stv_q [SLOTS];
  logic [SW-1:0]      cur_q, rr_q, pp_q;
  logic [1:0]         mode_q;
  logic [7:0]         limit_q;

  seq_e          seq_q, seq_d;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] idx;
  logic [4:0]    lvl_q;
  logic          found_q;
  logic [SW-1:0] sel_q, prev_q;
  logic [7:0]    most_q;
  logic [15:0]   acc_q, win_q;
  logic [15:0]   acc_add, lsum_total;
  logic [7:0]    np_q, tk_q;
  logic [15:0]   rnd_q;
  logic [2:0]    sts_q;
  logic [2:0]    oslot_q;
  logic          ovalid_q;
  logic          div_start, div_done;
  logic [15:0]   div_rem;
  logic          last;
  logic signed [9:0] aged;
  logic [7:0]    cnt_inc;
  logic [SW-1:0] ridx;

  assign idx  = SW'(cnt_q);
  assign last = (cnt_q == CW'(SLOTS - 1));

  // Scan index for rotating searches starts one past a pointer.
  function automatic logic [SW-1:0] rot(input logic [SW-1:0] p, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(k) + (CW+1)'(1);
    if (s >= (CW+1)'(SLOTS)) s = s - (CW+1)'(SLOTS);
    return SW'(s);
  endfunction

  // Ticket sum including the slot under the scan; the divider starts on the
  // last summing cycle with the complete total.
  assign acc_add    = acc_q + {8'd0, tik_q[idx]};
  assign lsum_total = (st_q[idx] == ST_READY) ? acc_add : acc_q;

  tss_div #(.DW(16)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(rnd_q),
    .divisor_i(lsum_total), .done_o(div_done), .rem_o(div_rem)
  );

  assign ridx = rot((seq_q == S_RR) ? rr_q : pp_q, cnt_q);

  assign cnt_inc = (stv_q[idx] == 8'hff) ? 8'hff : stv_q[idx] + 8'd1;
  assign aged = $signed(10'(base_q[idx])) - $signed(10'(cnt_inc));

  assign in_if.ready = (seq_q == S_IDLE) && !ovalid_q;
  assign div_start   = (seq_q == S_LSUM) && last && (lsum_total != '0);

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          unique case (in_if.data.op)
            OP_CREATE: seq_d = S_CREATE;
            OP_SCHEDULE, OP_EXIT, OP_BLOCK: seq_d = S_AGE;
            default: seq_d = S_OUT;
          endcase
        end
      end
      S_CREATE: if (last || st_q[idx] == ST_UNUSED) seq_d = S_OUT;
      S_AGE: begin
        if (last) begin
          unique case (mode_q)
            MODE_RR:   seq_d = S_RR;
            MODE_PRIO: seq_d = S_PSTARVE;
            MODE_LOT:  seq_d = S_LSUM;
            default:   seq_d = S_OUT;
          endcase
        end
      end
      S_RR: begin
        if (st_q[ridx] == ST_READY) seq_d = S_COMMIT;
        else if (last) seq_d = S_OUT;
      end
      S_PSTARVE: if (last) seq_d = S_PLVL;
      S_PLVL: begin
        if (found_q) seq_d = S_COMMIT;
        else if (st_q[ridx] == ST_READY && pri_q[ridx] == $signed({1'b0, lvl_q}))
          seq_d = S_COMMIT;
        else if (last && lvl_q == 5'(PRIO_MAX)) seq_d = S_OUT;
      end
      S_LSUM: if (last) seq_d = S_LDIV;
      S_LDIV: begin
        if (acc_q == '0) seq_d = S_OUT;
        else if (div_done) seq_d = S_LWALK;
      end
      S_LWALK: begin
        if (st_q[idx] == ST_READY && win_q < acc_add) seq_d = S_COMMIT;
        else if (last) seq_d = S_OUT;
      end
      S_COMMIT: seq_d = S_OUT;
      S_OUT: seq_d = S_IDLE;
      default: seq_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= S_IDLE;
      cnt_q    <= '0;
      mode_q   <= MODE_RR;
      limit_q  <= STARVE_RESET;
      cur_q    <= '0;
      rr_q     <= '0;
      pp_q     <= '0;
      ovalid_q <= 1'b0;
      found_q  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i]   <= (i == 0) ? ST_RUNNING : ST_UNUSED;
        pri_q[i]  <= '0;
        base_q[i] <= '0;
        tik_q[i]  <= (i == 0) ? 8'd1 : 8'd0;
        stv_q[i]  <= '0;
      end
    end else begin
      seq_q <= seq_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MODE) mode_q <= cfg_wdata_i[1:0];
        else limit_q <= cfg_wdata_i;
      end
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      // The scan counter restarts on every state change and wraps after the
      // last slot, which also steps the priority scan to its next level.
      if (seq_q != seq_d || seq_q == S_IDLE || last) cnt_q <= '0;
      else cnt_q <= cnt_q + 1'b1;

      unique case (seq_q)
        S_IDLE: begin
          found_q <= 1'b0;
          if (in_if.valid && in_if.ready) begin
            np_q   <= in_if.data.req_prio;
            tk_q   <= in_if.data.ticket_count;
            rnd_q  <= in_if.data.random_value;
            prev_q <= cur_q;
            sts_q  <= STS_DONE;
            oslot_q <= 3'(cur_q);
            acc_q  <= '0;
            most_q <= '0;
            lvl_q  <= 5'(PRIO_MIN);
            unique case (in_if.data.op)
              OP_EXIT:  st_q[cur_q] <= ST_UNUSED;
              OP_BLOCK: st_q[cur_q] <= ST_BLOCKED;
              OP_UNBLOCK: begin
                if (32'(in_if.data.wake_slot) < SLOTS &&
                    st_q[SW'(in_if.data.wake_slot)] == ST_BLOCKED)
                  st_q[SW'(in_if.data.wake_slot)] <= ST_READY;
              end
              default: ;
            endcase
          end
        end
        S_CREATE: begin
          if (st_q[idx] == ST_UNUSED) begin
            st_q[idx]   <= ST_READY;
            base_q[idx] <= (np_q > 8'(PRIO_MAX)) ? 4'(PRIO_MAX) :
                           (np_q < 8'(PRIO_MIN)) ? 4'(PRIO_MIN) : np_q[3:0];
            pri_q[idx]  <= (np_q > 8'(PRIO_MAX)) ? 6'(PRIO_MAX) :
                           (np_q < 8'(PRIO_MIN)) ? 6'(PRIO_MIN) : {2'b0, np_q[3:0]};
            stv_q[idx]  <= '0;
            tik_q[idx]  <= (tk_q == 8'd0) ? 8'd1 : tk_q;
            sts_q       <= STS_CREATED;
            oslot_q     <= 3'(idx);
          end else if (last) begin
            sts_q   <= STS_FULL;
            oslot_q <= '0;
          end
        end
        S_AGE: begin
          if (idx == cur_q && st_q[idx] == ST_RUNNING) begin
            stv_q[idx] <= '0;
            if (mode_q == MODE_PRIO) pri_q[idx] <= $signed({2'b0, base_q[idx]});
          end else if (st_q[idx] == ST_READY) begin
            stv_q[idx] <= cnt_inc;
            if (mode_q == MODE_PRIO) begin
              if (cnt_inc > limit_q) pri_q[idx] <= 6'(PRIO_MIN) - 6'd1;
              else if (aged < $signed(10'(PRIO_MIN))) pri_q[idx] <= 6'(PRIO_MIN);
              else pri_q[idx] <= 6'(aged);
            end
          end
          sts_q <= STS_NONE;
        end
        S_RR: begin
          if (st_q[ridx] == ST_READY) begin
            sel_q <= ridx;
            rr_q  <= ridx;
          end
        end
        S_PSTARVE: begin
          if (st_q[idx] == ST_READY && stv_q[idx] > limit_q &&
              (!found_q || stv_q[idx] > most_q)) begin
            found_q <= 1'b1;
            sel_q   <= idx;
            most_q  <= stv_q[idx];
          end
        end
        S_PLVL: begin
          if (!found_q && st_q[ridx] == ST_READY &&
              pri_q[ridx] == $signed({1'b0, lvl_q})) begin
            sel_q <= ridx;
            pp_q  <= ridx;
          end
          if (last) lvl_q <= lvl_q + 5'd1;
        end
        S_LSUM: if (st_q[idx] == ST_READY) acc_q <= acc_add;
        S_LDIV: begin
          if (div_done) begin
            win_q <= div_rem;
            acc_q <= '0;
          end
        end
        S_LWALK: begin
          if (st_q[idx] == ST_READY) begin
            acc_q <= acc_add;
            if (win_q < acc_add) sel_q <= idx;
          end
        end
        S_COMMIT: begin
          // The old slot goes back to ready unless it left the table, blocked
          // or is picked again.
          if (sel_q != cur_q && st_q[cur_q] != ST_UNUSED && st_q[cur_q] != ST_BLOCKED)
            st_q[cur_q] <= ST_READY;
          st_q[sel_q] <= ST_RUNNING;
          cur_q   <= sel_q;
          sts_q   <= STS_SWITCHED;
          oslot_q <= 3'(sel_q);
        end
        S_OUT: ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_if.valid          = ovalid_q;
  assign out_if.data.status    = sts_q;
  assign out_if.data.slot      = oslot_q;
  assign out_if.data.prev_slot = 3'(prev_q);
endmodule

/* rtl/core/tss_div.sv */
// Restoring divider giving the remainder of a 16-bit value by a divisor,
// one bit per cycle. Depends on tss_pkg only by convention of the project.
module tss_div import tss_pkg::*; #(
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] rem_o
);
  localparam int unsigned CW = $clog2(DW + 1);
  logic [DW-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   trial;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    rem_d = trial[DW-1:0];
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = DW'(trial - {1'b0, dvs_q});
    end
    quo_d = {quo_q[DW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;
endmodule

/* test/thread_slot_scheduler_tb.sv */
// Self-checking testbench for the thread slot scheduler: drives op words, predicts
// every status word with an in-bench slot table model and compares field by field.
// Depends on tss_pkg, tss_if and the thread_slot_scheduler RTL.
module thread_slot_scheduler_tb;
  import tss_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int PLO = PRIO_MIN_DEF;
  localparam int PHI = PRIO_MAX_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [2:0] OP_FIRST_RSVD = 3'd5;
  localparam logic [2:0] OP_MID_RSVD = 3'd6;
  localparam logic [2:0] OP_LAST_RSVD = 3'd7;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_idx = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  tss_if #(.T(op_word_t)) op_ch ();
  tss_if #(.T(status_word_t)) status_ch ();

  thread_slot_scheduler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (op_ch.sink),
    .out_if      (status_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the slot table and registers, advanced once per accepted word.
  slot_state_e tbl_state [NSLOT];
  int          tbl_prio [NSLOT];
  int          tbl_base [NSLOT];
  int          tbl_tickets [NSLOT];
  int          tbl_starve [NSLOT];
  int          cur_slot, rr_ptr, prio_ptr;
  logic [1:0]  cur_mode;
  int          cur_limit;

  op_word_t     pending_ops[$];
  status_word_t expected_status[$];

  int errors = 0;
  int words_in = 0, words_out = 0, switches = 0, creates_ok = 0, full_hits = 0;
  bit op_taken = 1'b0;
  int op_gap = 0;
  int rx_stall = 0;
  int long_hold_req = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH word %0d: %s got %0d expected %0d", words_out, what, got, want);
  endtask

  function automatic void reset_table();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_state[i] = ST_UNUSED;
      tbl_prio[i] = 0;
      tbl_base[i] = 0;
      tbl_tickets[i] = 0;
      tbl_starve[i] = 0;
    end
    tbl_state[0] = ST_RUNNING;
    tbl_tickets[0] = 1;
    cur_slot = 0;
    rr_ptr = 0;
    prio_ptr = 0;
    cur_mode = MODE_RR;
    cur_limit = STARVE_RESET;
  endfunction

  // Aging pass run at the start of every schedule, exit and block op.
  function automatic void age_table();
    int p;
    if (tbl_state[cur_slot] == ST_RUNNING) begin
      tbl_starve[cur_slot] = 0;
      if (cur_mode == MODE_PRIO) tbl_prio[cur_slot] = tbl_base[cur_slot];
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_state[i] == ST_READY) begin
        if (tbl_starve[i] < 255) tbl_starve[i]++;
        if (cur_mode == MODE_PRIO) begin
          p = tbl_base[i] - tbl_starve[i];
          if (p < PLO) p = PLO;
          if (tbl_starve[i] > cur_limit) p = PLO - 1;
          tbl_prio[i] = p;
        end
      end
    end
  endfunction

  function automatic int pick_next(input int rnd);
    int sel, most, idx, total, acc, win;
    sel = -1;
    case (cur_mode)
      MODE_RR: begin
        for (int k = 0; k < NSLOT && sel < 0; k++) begin
          idx = (rr_ptr + 1 + k) % NSLOT;
          if (tbl_state[idx] == ST_READY) begin
            sel = idx;
            rr_ptr = idx;
          end
        end
      end
      MODE_PRIO: begin
        // A slot starved past the limit wins outright; the most starved first.
        most = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_state[i] == ST_READY && tbl_starve[i] > cur_limit && tbl_starve[i] > most) begin
            sel = i;
            most = tbl_starve[i];
          end
        end
        for (int lvl = PLO; lvl <= PHI && sel < 0; lvl++) begin
          for (int k = 0; k < NSLOT && sel < 0; k++) begin
            idx = (prio_ptr + 1 + k) % NSLOT;
            if (tbl_state[idx] == ST_READY && tbl_prio[idx] == lvl) begin
              sel = idx;
              prio_ptr = idx;
            end
          end
        end
      end
      MODE_LOT: begin
        total = 0;
        acc = 0;
        for (int i = 0; i < NSLOT; i++)
          if (tbl_state[i] == ST_READY) total += tbl_tickets[i];
        if (total != 0) begin
          win = rnd % total;
          for (int i = 0; i < NSLOT && sel < 0; i++) begin
            if (tbl_state[i] == ST_READY) begin
              acc += tbl_tickets[i];
              if (win < acc) sel = i;
            end
          end
        end
      end
      default: sel = -1;
    endcase
    return sel;
  endfunction

  // Works out the status word that one op word must produce and updates the table.
  function automatic status_word_t predict_status(input op_word_t w);
    status_word_t r;
    int pr, pick;
    bit found;
    r.prev_slot = cur_slot[2:0];
    r.status = STS_DONE;
    r.slot = cur_slot[2:0];
    found = 1'b0;
    if (w.op == OP_CREATE) begin
      r.status = STS_FULL;
      r.slot = '0;
      for (int i = 0; i < NSLOT && !found; i++) begin
        if (tbl_state[i] == ST_UNUSED) begin
          pr = w.req_prio;
          if (pr < PLO) pr = PLO;
          if (pr > PHI) pr = PHI;
          tbl_state[i] = ST_READY;
          tbl_prio[i] = pr;
          tbl_base[i] = pr;
          tbl_starve[i] = 0;
          tbl_tickets[i] = (w.ticket_count == 0) ? 1 : w.ticket_count;
          r.status = STS_CREATED;
          r.slot = i[2:0];
          found = 1'b1;
        end
      end
    end else if (w.op == OP_SCHEDULE || w.op == OP_EXIT || w.op == OP_BLOCK) begin
      if (w.op == OP_EXIT) tbl_state[cur_slot] = ST_UNUSED;
      if (w.op == OP_BLOCK) tbl_state[cur_slot] = ST_BLOCKED;
      age_table();
      pick = pick_next(w.random_value);
      if (pick < 0) begin
        r.status = STS_NONE;
      end else begin
        if (tbl_state[cur_slot] != ST_UNUSED && tbl_state[cur_slot] != ST_BLOCKED)
          tbl_state[cur_slot] = ST_READY;
        tbl_state[pick] = ST_RUNNING;
        cur_slot = pick;
        r.status = STS_SWITCHED;
      end
      r.slot = cur_slot[2:0];
    end else if (w.op == OP_UNBLOCK) begin
      if (tbl_state[w.wake_slot] == ST_BLOCKED) tbl_state[w.wake_slot] = ST_READY;
    end
    return r;
  endfunction

  // Accepted words on both channels are sampled here, at the rising edge.
  always @(posedge clk_i) begin
    status_word_t want;
    status_word_t got;
    op_word_t w;
    if (rst_ni) begin
      idle_cycles++;
      if (op_ch.valid && op_ch.ready) begin
        w = pending_ops.pop_front();
        expected_status.push_back(predict_status(w));
        words_in++;
        op_taken = 1'b1;
        idle_cycles = 0;
      end
      if (status_ch.valid && status_ch.ready) begin
        got = status_ch.data;
        words_out++;
        idle_cycles = 0;
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected status word, status", got.status, 0);
        end else begin
          want = expected_status.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
          if (got.prev_slot != want.prev_slot)
            report_mismatch("prev_slot", got.prev_slot, want.prev_slot);
          if (want.status == STS_SWITCHED) switches++;
          if (want.status == STS_CREATED) creates_ok++;
          if (want.status == STS_FULL) full_hits++;
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Sender: offers the head of the pending queue, with random gaps between words.
  always @(negedge clk_i) begin
    logic v;
    if (rst_ni && (!op_ch.valid || op_taken)) begin
      op_taken = 1'b0;
      v = 1'b0;
      if (op_gap > 0) begin
        op_gap--;
      end else if (pending_ops.size() > 0) begin
        v = 1'b1;
        op_ch.data <= pending_ops[0];
        op_gap = draw_gap();
      end
      op_ch.valid <= v;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request to back up the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_req > 0) begin
        rx_stall = long_hold_req;
        long_hold_req = 0;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        status_ch.ready <= 1'b0;
      end else begin
        rx_stall = draw_gap();
        status_ch.ready <= (rx_stall == 0);
      end
    end
  end

  task automatic add_op(input logic [2:0] op, input int prio, input int tickets,
                        input int rnd, input int wake);
    op_word_t w;
    w.op = op;
    w.req_prio = prio[7:0];
    w.ticket_count = tickets[7:0];
    w.random_value = rnd[15:0];
    w.wake_slot = wake[2:0];
    pending_ops.push_back(w);
  endtask

  task automatic add_random_ops(input int count);
    int r;
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) op = OP_CREATE;
      else if (r < 55) op = OP_SCHEDULE;
      else if (r < 65) op = OP_EXIT;
      else if (r < 80) op = OP_BLOCK;
      else if (r < 96) op = OP_UNBLOCK;
      else op = 3'($urandom_range(OP_FIRST_RSVD, OP_LAST_RSVD));
      add_op(op, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535),
             $urandom_range(0, NSLOT - 1));
    end
  endtask

  task automatic wait_idle();
    while (pending_ops.size() > 0 || expected_status.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle; the shadow copy follows at once.
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    if (idx == CFG_MODE) cur_mode = value[1:0];
    else cur_limit = value[7:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] mode, input int limit, input int count);
    wait_idle();
    write_reg(CFG_MODE, mode);
    write_reg(CFG_STARVE, limit);
    add_random_ops(count);
  endtask

  initial begin
    op_ch.valid = 1'b0;
    op_ch.data = '0;
    status_ch.ready = 1'b0;
    reset_table();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: priority and ticket extremes, a full table, every op,
    // unblock of a slot that is not blocked, reserved ops.
    add_op(OP_SCHEDULE, 0, 0, 0, 0);
    add_op(OP_UNBLOCK, 0, 0, 0, 3);
    add_op(OP_CREATE, 0, 0, 0, 0);
    add_op(OP_CREATE, 255, 255, 0, 0);
    add_op(OP_CREATE, 15, 1, 0, 0);
    add_op(OP_CREATE, 16, 128, 0, 0);
    add_op(OP_CREATE, 7, 2, 0, 0);
    add_op(OP_CREATE, 3, 9, 0, 0);
    add_op(OP_CREATE, 1, 254, 0, 0);
    add_op(OP_CREATE, 9, 5, 0, 0);
    add_op(OP_SCHEDULE, 0, 0, 65535, 0);
    add_op(OP_BLOCK, 0, 0, 0, 0);
    add_op(OP_UNBLOCK, 0, 0, 0, 1);
    add_op(OP_UNBLOCK, 0, 0, 0, 7);
    add_op(OP_EXIT, 0, 0, 0, 0);
    add_op(OP_FIRST_RSVD, 255, 255, 65535, 7);
    add_op(OP_LAST_RSVD, 0, 0, 0, 0);
    add_op(OP_MID_RSVD, 0, 0, 0, 0);
    add_op(OP_EXIT, 0, 0, 0, 0);
    add_op(OP_SCHEDULE, 0, 0, 0, 0);

    run_phase(MODE_PRIO, 0, 50);
    run_phase(MODE_PRIO, 255, 50);
    run_phase(MODE_LOT, 255, 50);
    // Hold the receiver off while the sender keeps offering, so the input stalls.
    long_hold_req = 300;
    run_phase(MODE_PRIO, 3, 60);
    run_phase(MODE_UNDEF, 10, 25);
    run_phase(MODE_RR, 128, 50);
    run_phase(MODE_LOT, 0, 50);
    run_phase(MODE_PRIO, 10, 50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d op words and %0d status words over all four modes,", words_in,
             words_out);
    $display("with %0d switches, %0d creates and %0d full-table answers", switches,
             creates_ok, full_hits);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tss_pkg.sv
rtl/core/tss_if.sv
rtl/core/tss_div.sv
rtl/core/thread_slot_scheduler.sv
test/thread_slot_scheduler_tb.sv
